FILE: src/adcavg_pkg.sv
// adcavg_pkg: shared constants, register indexes and pipeline types of the
// multichannel ADC sample averager. No dependencies.
package adcavg_pkg;

  localparam int CHANNELS = 12;
  localparam int WINDOW   = 16;

  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 12;
  localparam int CH_W     = 4;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int SUM_W    = SAMPLE_W + SLOT_W;
  localparam int CHIDX_W  = $clog2(CHANNELS);
  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int CHAN_LSB   = 26;
  localparam int SAMPLE_LSB = 4;

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_CHANNEL = 1'd1;

  // item held between the store read and the accumulate/report step
  typedef struct packed {
    logic                valid;
    logic                drop;
    logic [CH_W-1:0]     ch;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
    logic                fwd;
    logic [SAMPLE_W-1:0] fwd_sample;
  } stage_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered_value;
    logic                channel_dropped;
  } result_t;

endpackage

FILE: src/adcavg_if.sv
// adcavg_word_if / adcavg_result_if: valid-ready channels of the averager.
// Depends on adcavg_pkg for the payload widths.
interface adcavg_word_if;
  logic                             valid;
  logic                             ready;
  logic [adcavg_pkg::WORD_W-1:0]    gdat_word;

  modport source (output valid, output gdat_word, input ready);
  modport sink   (input valid, input gdat_word, output ready);
endinterface

interface adcavg_result_if;
  logic                             valid;
  logic                             ready;
  logic [adcavg_pkg::SAMPLE_W-1:0]  filtered_value;
  logic                             channel_dropped;

  modport source (output valid, output filtered_value, output channel_dropped, input ready);
  modport sink   (input valid, input filtered_value, input channel_dropped, output ready);
endinterface

FILE: src/adcavg_store.sv
// adcavg_store: sample ring memory of all channels with registered read and
// per-entry valid bits so that never-written entries read as zero.
// Depends on adcavg_pkg.
module adcavg_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                re,
  input  logic [adcavg_pkg::ADDR_W-1:0]       ra,
  output logic [adcavg_pkg::SAMPLE_W-1:0]     rd,
  input  logic                                we,
  input  logic [adcavg_pkg::ADDR_W-1:0]       wa,
  input  logic [adcavg_pkg::SAMPLE_W-1:0]     wd
);

  logic [adcavg_pkg::SAMPLE_W-1:0] mem [adcavg_pkg::DEPTH];
  logic [adcavg_pkg::DEPTH-1:0]    vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= vld[ra] ? mem[ra] : '0;
    end
  end

endmodule

FILE: src/adcavg_front.sv
// adcavg_front: decodes the input word, keeps the per-channel slot indexes,
// issues the store read and holds the item for the accumulate step.
// Depends on adcavg_pkg.
module adcavg_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                advance,
  input  logic [adcavg_pkg::WORD_W-1:0]       gdat_word,
  input  logic                                filter_mode,
  output logic                                rd_en,
  output logic [adcavg_pkg::ADDR_W-1:0]       rd_addr,
  output adcavg_pkg::stage_t                  stage
);

  logic [adcavg_pkg::SLOT_W-1:0]   slot_index [adcavg_pkg::CHANNELS];
  logic [adcavg_pkg::CH_W-1:0]     ch;
  logic [adcavg_pkg::CHIDX_W-1:0]  ch_idx;
  logic [adcavg_pkg::SAMPLE_W-1:0] sample;
  logic                            drop;
  logic [adcavg_pkg::SLOT_W-1:0]   idx;
  logic [adcavg_pkg::SLOT_W-1:0]   idx_next;
  logic [adcavg_pkg::SLOT_W-1:0]   slot;
  logic                            fwd;

  always_comb begin
    ch       = gdat_word[adcavg_pkg::CHAN_LSB +: adcavg_pkg::CH_W];
    ch_idx   = ch[adcavg_pkg::CHIDX_W-1:0];
    sample   = gdat_word[adcavg_pkg::SAMPLE_LSB +: adcavg_pkg::SAMPLE_W];
    drop     = (32'(ch) >= adcavg_pkg::CHANNELS);
    idx      = slot_index[ch_idx];
    idx_next = (32'(idx) == adcavg_pkg::WINDOW - 1) ? '0 : idx + 1'b1;
    // raw mode always lands in slot 0, the index still moves on
    slot     = filter_mode ? idx : '0;
    rd_en    = accept && !drop;
    rd_addr  = adcavg_pkg::ADDR_W'({ch, slot});
    // the held item writes its entry at this same edge
    fwd      = stage.valid && !stage.drop && (stage.ch == ch) && (stage.slot == slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < adcavg_pkg::CHANNELS; i++) begin
        slot_index[i] <= '0;
      end
    end else if (accept && !drop) begin
      slot_index[ch_idx] <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.drop       <= drop;
      stage.ch         <= ch;
      stage.slot       <= slot;
      stage.sample     <= sample;
      stage.fwd        <= fwd;
      stage.fwd_sample <= stage.sample;
    end
  end

endmodule

FILE: src/adcavg_accum.sv
// adcavg_accum: running window sums and slot-0 copies per channel, store
// write-back and the reported value of the read channel.
// Depends on adcavg_pkg.
module adcavg_accum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  adcavg_pkg::stage_t                  stage,
  input  logic [adcavg_pkg::SAMPLE_W-1:0]     rd,
  input  logic                                filter_mode,
  input  logic [adcavg_pkg::CH_W-1:0]         read_channel,
  output logic                                we,
  output logic [adcavg_pkg::ADDR_W-1:0]       wa,
  output logic [adcavg_pkg::SAMPLE_W-1:0]     wd,
  output adcavg_pkg::result_t                 result
);

  // two copies of the sums: one read at the item's channel, one at read_channel
  logic [adcavg_pkg::SUM_W-1:0]    sum_upd [adcavg_pkg::CHANNELS];
  logic [adcavg_pkg::SUM_W-1:0]    sum_rep [adcavg_pkg::CHANNELS];
  logic [adcavg_pkg::SAMPLE_W-1:0] slot0   [adcavg_pkg::CHANNELS];

  logic [adcavg_pkg::CHIDX_W-1:0]  ch_idx;
  logic [adcavg_pkg::CHIDX_W-1:0]  rc_idx;
  logic [adcavg_pkg::SAMPLE_W-1:0] old_sample;
  logic [adcavg_pkg::SUM_W-1:0]    sum_next;
  logic                            rc_ok;
  logic                            hit;
  logic [adcavg_pkg::SUM_W-1:0]    avg_sum;
  logic [adcavg_pkg::SAMPLE_W-1:0] raw_value;
  logic                            update;

  always_comb begin
    ch_idx     = stage.ch[adcavg_pkg::CHIDX_W-1:0];
    rc_idx     = read_channel[adcavg_pkg::CHIDX_W-1:0];
    update     = advance && !stage.drop;
    old_sample = stage.fwd ? stage.fwd_sample : rd;
    sum_next   = sum_upd[ch_idx] - adcavg_pkg::SUM_W'(old_sample)
                 + adcavg_pkg::SUM_W'(stage.sample);

    we = update;
    wa = adcavg_pkg::ADDR_W'({stage.ch, stage.slot});
    wd = stage.sample;

    // report the read channel as it stands after this item
    rc_ok     = (32'(read_channel) < adcavg_pkg::CHANNELS);
    hit       = !stage.drop && (stage.ch == read_channel);
    avg_sum   = hit ? sum_next : sum_rep[rc_idx];
    raw_value = (hit && stage.slot == '0) ? stage.sample : slot0[rc_idx];

    if (!rc_ok) begin
      result.filtered_value = '0;
    end else if (filter_mode) begin
      result.filtered_value = adcavg_pkg::SAMPLE_W'(avg_sum >> adcavg_pkg::SLOT_W);
    end else begin
      result.filtered_value = raw_value;
    end
    result.channel_dropped = stage.drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < adcavg_pkg::CHANNELS; i++) begin
        sum_upd[i] <= '0;
        sum_rep[i] <= '0;
        slot0[i]   <= '0;
      end
    end else if (update) begin
      sum_upd[ch_idx] <= sum_next;
      sum_rep[ch_idx] <= sum_next;
      if (stage.slot == '0) begin
        slot0[ch_idx] <= stage.sample;
      end
    end
  end

endmodule

FILE: src/multichannel_adc_sample_averager.sv
// Multichannel ADC sample averager: one ADC data word per request, one result
// per request, a new word every cycle while input ready stays high. The store
// read is taken at the edge that accepts a word; the sum update and report run
// when the held stage item moves on into the output register. The
// output register parts the two sides, so a word is still taken while a
// result waits, and input ready drops only when both stages are full and the
// waiting result is not taken. A word for channel 12 to 15 changes nothing and
// returns channel_dropped set. Write filter_mode and read_channel only while
// no request is in flight.
// Depends on adcavg_pkg, adcavg_if, adcavg_front, adcavg_store, adcavg_accum.
module multichannel_adc_sample_averager (
  input  logic                                clk,
  input  logic                                rst,
  adcavg_word_if.sink                         words,
  adcavg_result_if.source                     results,
  input  logic                                cfg_we,
  input  logic [adcavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adcavg_pkg::CFG_W-1:0]        cfg_data
);

  logic                            filter_mode;
  logic [adcavg_pkg::CH_W-1:0]     read_channel;
  logic                            accept;
  logic                            advance;
  logic                            rd_en;
  logic [adcavg_pkg::ADDR_W-1:0]   rd_addr;
  logic [adcavg_pkg::SAMPLE_W-1:0] rd_data;
  logic                            we;
  logic [adcavg_pkg::ADDR_W-1:0]   wa;
  logic [adcavg_pkg::SAMPLE_W-1:0] wd;
  adcavg_pkg::stage_t              stage;
  adcavg_pkg::result_t             result;
  logic                            out_valid;
  adcavg_pkg::result_t             out_data;

  always_comb begin
    advance      = stage.valid && (!out_valid || results.ready);
    words.ready  = !stage.valid || advance;
    accept       = words.valid && words.ready;
    results.valid           = out_valid;
    results.filtered_value  = out_data.filtered_value;
    results.channel_dropped = out_data.channel_dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= 1'b0;
      read_channel <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        adcavg_pkg::REG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        adcavg_pkg::REG_READ_CHANNEL: read_channel <= cfg_data[adcavg_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  adcavg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .advance     (advance),
    .gdat_word   (words.gdat_word),
    .filter_mode (filter_mode),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .stage       (stage)
  );

  adcavg_store u_store (
    .clk (clk),
    .rst (rst),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (rd_data),
    .we  (we),
    .wa  (wa),
    .wd  (wd)
  );

  adcavg_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .stage        (stage),
    .rd           (rd_data),
    .filter_mode  (filter_mode),
    .read_channel (read_channel),
    .we           (we),
    .wa           (wa),
    .wd           (wd),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

FILE: src/adcavg_checker.sv
// adcavg_checker: port-level assertions of the averager, bound to the top.
// Depends on adcavg_pkg and multichannel_adc_sample_averager.
module adcavg_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [adcavg_pkg::WORD_W-1:0]       gdat_word,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [adcavg_pkg::SAMPLE_W-1:0]     filtered_value,
  input  logic                                channel_dropped
);

  logic in_acc;
  logic in_drop;

  assign in_acc  = in_valid && in_ready;
  assign in_drop = (32'(gdat_word[adcavg_pkg::CHAN_LSB +: adcavg_pkg::CH_W])
                    >= adcavg_pkg::CHANNELS);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value)
                                && $stable(channel_dropped))
    else $error("stalled result changed");

  a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_drop_reported: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_drop) ##1 out_ready |=> out_valid && channel_dropped)
    else $error("dropped channel not flagged two cycles later");

endmodule

bind multichannel_adc_sample_averager adcavg_checker u_adcavg_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (words.valid),
  .in_ready        (words.ready),
  .gdat_word       (words.gdat_word),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .filtered_value  (results.filtered_value),
  .channel_dropped (results.channel_dropped)
);

FILE: verif/multichannel_adc_sample_averager_tb.sv
// Self-checking testbench of multichannel_adc_sample_averager: a directed table, then
// random ADC words in phases of varying mode and read channel. Uses adcavg_pkg and adcavg_if.
`timescale 1ns / 100ps

module multichannel_adc_sample_averager_tb;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [adcavg_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [adcavg_pkg::CFG_W-1:0]      reg_val;
    logic [adcavg_pkg::WORD_W-1:0]     word;
    logic                              typed;
    adcavg_pkg::result_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                             cfg_we;
  logic [adcavg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [adcavg_pkg::CFG_W-1:0]     cfg_data;

  adcavg_word_if   words_if();
  adcavg_result_if results_if();

  multichannel_adc_sample_averager uut (
    .clk       (clk),
    .rst       (rst),
    .words     (words_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [adcavg_pkg::SAMPLE_W-1:0] ring_mem [adcavg_pkg::CHANNELS][adcavg_pkg::WINDOW];
  logic [adcavg_pkg::SLOT_W-1:0]   next_slot [adcavg_pkg::CHANNELS];
  logic [adcavg_pkg::SUM_W-1:0]    ring_sum [adcavg_pkg::CHANNELS];
  logic                            avg_mode;
  logic [adcavg_pkg::CH_W-1:0]     report_ch;

  adcavg_pkg::result_t pending_averages[$];
  stim_row_t           directed_rows[$];
  int                  mismatch_count = 0;
  bit                  tx_pause_on;
  bit                  rx_pause_on;

  function automatic adcavg_pkg::result_t predict_average(
      input logic [adcavg_pkg::WORD_W-1:0] w);
    logic [adcavg_pkg::CH_W-1:0]     ch;
    logic [adcavg_pkg::SAMPLE_W-1:0] s;
    logic [adcavg_pkg::SLOT_W-1:0]   slot;
    logic [adcavg_pkg::SUM_W-1:0]    mean;
    adcavg_pkg::result_t             r;
    ch = w[adcavg_pkg::CHAN_LSB +: adcavg_pkg::CH_W];
    s  = w[adcavg_pkg::SAMPLE_LSB +: adcavg_pkg::SAMPLE_W];
    r.channel_dropped = (ch >= adcavg_pkg::CHANNELS);
    if (!r.channel_dropped) begin
      // raw mode always overwrites slot 0 but keeps the running sum honest
      slot = avg_mode ? next_slot[ch] : '0;
      ring_sum[ch] = ring_sum[ch] - adcavg_pkg::SUM_W'(ring_mem[ch][slot])
                     + adcavg_pkg::SUM_W'(s);
      ring_mem[ch][slot] = s;
      next_slot[ch] = next_slot[ch] + 1'b1;
    end
    if (report_ch >= adcavg_pkg::CHANNELS) begin
      r.filtered_value = '0;
    end else if (!avg_mode) begin
      r.filtered_value = ring_mem[report_ch][0];
    end else begin
      mean = adcavg_pkg::SUM_W'(ring_sum[report_ch] / adcavg_pkg::WINDOW);
      r.filtered_value = mean[adcavg_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [adcavg_pkg::WORD_W-1:0] adc_word(input int ch, input int sample,
      input logic [adcavg_pkg::WORD_W-1:0] junk);
    logic [adcavg_pkg::WORD_W-1:0] w;
    w = junk;
    w[adcavg_pkg::CHAN_LSB +: adcavg_pkg::CH_W] = adcavg_pkg::CH_W'(ch);
    w[adcavg_pkg::SAMPLE_LSB +: adcavg_pkg::SAMPLE_W] = adcavg_pkg::SAMPLE_W'(sample);
    return w;
  endfunction

  function automatic stim_row_t row_word(input logic [adcavg_pkg::WORD_W-1:0] w);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.word = w;
    return r;
  endfunction

  function automatic stim_row_t row_checked(input logic [adcavg_pkg::WORD_W-1:0] w,
                                            input int value, input logic dropped);
    stim_row_t r;
    r = row_word(w);
    r.typed = 1'b1;
    r.want.filtered_value = adcavg_pkg::SAMPLE_W'(value);
    r.want.channel_dropped = dropped;
    return r;
  endfunction

  function automatic stim_row_t row_reg(input logic [adcavg_pkg::CFG_IDX_W-1:0] idx,
                                        input int value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = adcavg_pkg::CFG_W'(value);
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_word(input logic [adcavg_pkg::WORD_W-1:0] w, input logic typed,
                           input adcavg_pkg::result_t want);
    int                  gap;
    adcavg_pkg::result_t pred;
    gap = tx_pause_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      words_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    words_if.valid <= 1'b1;
    words_if.gdat_word <= w;
    @(posedge clk);
    while (!words_if.ready) @(posedge clk);
    pred = predict_average(w);
    pending_averages.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // register writes only once every request has come back
  task automatic apply_reg(input logic [adcavg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [adcavg_pkg::CFG_W-1:0] value);
    words_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == adcavg_pkg::REG_FILTER_MODE) avg_mode = value[0];
    else report_ch = value;
    @(negedge clk);
  endtask

  // result side: per request stall, then hold ready until a result is taken
  initial begin
    int stall;
    results_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_pause_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
      while (!results_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    adcavg_pkg::result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected result: value %h dropped %b", $time,
                 results_if.filtered_value, results_if.channel_dropped);
        mismatch_count++;
      end else begin
        want = pending_averages.pop_front();
        if (results_if.filtered_value !== want.filtered_value) begin
          $display("%0t: filtered_value expected %h actual %h", $time,
                   want.filtered_value, results_if.filtered_value);
          mismatch_count++;
        end
        if (results_if.channel_dropped !== want.channel_dropped) begin
          $display("%0t: channel_dropped expected %b actual %b", $time,
                   want.channel_dropped, results_if.channel_dropped);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL multichannel_adc_sample_averager");
    $finish;
  end

  initial begin
    int                  pick;
    int                  ch;
    int                  sample;
    int                  drain;
    int                  mode;
    int                  rch;
    adcavg_pkg::result_t none;
    stim_row_t           row;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    words_if.valid = 1'b0;
    words_if.gdat_word = '0;
    none = '0;
    tx_pause_on = 1'b1;
    rx_pause_on = 1'b1;
    for (int c = 0; c < adcavg_pkg::CHANNELS; c++) begin
      next_slot[c] = '0;
      ring_sum[c] = '0;
      for (int s = 0; s < adcavg_pkg::WINDOW; s++) ring_mem[c][s] = '0;
    end
    avg_mode = 1'b0;
    report_ch = '0;

    // raw mode, read channel 0 after reset
    directed_rows.push_back(row_checked(adc_word(0, 'h000, '0), 'h000, 1'b0));
    directed_rows.push_back(row_checked(adc_word(0, 'hFFF, '1), 'hFFF, 1'b0));
    directed_rows.push_back(row_checked(32'hFFFF_FFFF, 'hFFF, 1'b1));
    directed_rows.push_back(row_checked(adc_word(12, 'h000, '0), 'hFFF, 1'b1));
    directed_rows.push_back(row_checked(adc_word(11, 'hABC, '0), 'hFFF, 1'b0));
    directed_rows.push_back(row_reg(adcavg_pkg::REG_READ_CHANNEL, 11));
    directed_rows.push_back(row_checked(adc_word(11, 'h123, '1), 'h123, 1'b0));
    // read channel beyond the last one reports zero
    directed_rows.push_back(row_reg(adcavg_pkg::REG_READ_CHANNEL, 15));
    directed_rows.push_back(row_checked(adc_word(3, 'h800, '0), 'h000, 1'b0));
    directed_rows.push_back(row_checked(adc_word(13, 'hFFF, '1), 'h000, 1'b1));
    directed_rows.push_back(row_reg(adcavg_pkg::REG_FILTER_MODE, 1));
    directed_rows.push_back(row_reg(adcavg_pkg::REG_READ_CHANNEL, 0));
    repeat (4) directed_rows.push_back(row_word(adc_word(0, 'hFFF, '0)));
    directed_rows.push_back(row_word(adc_word(14, 'h7FF, '0)));
    directed_rows.push_back(row_reg(adcavg_pkg::REG_READ_CHANNEL, 12));
    directed_rows.push_back(row_checked(adc_word(0, 'hFFF, '0), 'h000, 1'b0));
    // raw write to slot 0, then the average must see it
    directed_rows.push_back(row_reg(adcavg_pkg::REG_FILTER_MODE, 0));
    directed_rows.push_back(row_reg(adcavg_pkg::REG_READ_CHANNEL, 0));
    directed_rows.push_back(row_word(adc_word(0, 'h555, '0)));
    directed_rows.push_back(row_reg(adcavg_pkg::REG_FILTER_MODE, 1));
    directed_rows.push_back(row_word(adc_word(7, 'h000, '0)));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) apply_reg(row.reg_idx, row.reg_val);
      else send_word(row.word, row.typed, row.want);
    end

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin mode = 0; rch = 0; end
        1: begin mode = 1; rch = 0; end
        2: begin mode = 1; rch = 11; end
        3: begin mode = 0; rch = 11; end
        4: begin mode = 1; rch = 12; end
        5: begin mode = 0; rch = 15; end
        default: begin
          mode = $urandom_range(0, 1);
          rch = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
        end
      endcase
      apply_reg(adcavg_pkg::REG_FILTER_MODE, adcavg_pkg::CFG_W'(mode));
      apply_reg(adcavg_pkg::REG_READ_CHANNEL, adcavg_pkg::CFG_W'(rch));
      // first phase runs back to back on both sides
      tx_pause_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_pause_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          ch = (report_ch < adcavg_pkg::CHANNELS) ? int'(report_ch)
                                                  : $urandom_range(0, 11);
        end else if (pick < 9) ch = $urandom_range(0, 11);
        else ch = $urandom_range(12, 15);
        pick = $urandom_range(0, 7);
        if (pick == 0) sample = 0;
        else if (pick == 1) sample = 'hFFF;
        else sample = $urandom_range(0, 'hFFF);
        send_word(adc_word(ch, sample, $urandom()), 1'b0, none);
      end
    end

    words_if.valid <= 1'b0;
    drain = 0;
    while (pending_averages.size() != 0 && drain < 2000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);
    if (pending_averages.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_averages.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS multichannel_adc_sample_averager");
    end else begin
      $display("FAIL multichannel_adc_sample_averager");
    end
    $finish;
  end

endmodule
